// ===== rtl/teg_pkg.sv =====
// Shared types and constants for the text encoding guesser.
package teg_pkg;

  localparam int NUM_ENC = 6;
  localparam int ENC_W   = 3;
  localparam int SCORE_W = 30;

  localparam logic [ENC_W-1:0] E_ASCII  = 3'd0;
  localparam logic [ENC_W-1:0] E_UTF8   = 3'd1;
  localparam logic [ENC_W-1:0] E_BINARY = 3'd2;
  localparam logic [ENC_W-1:0] E_JIS    = 3'd3;
  localparam logic [ENC_W-1:0] E_EUCJP  = 3'd4;
  localparam logic [ENC_W-1:0] E_SJIS   = 3'd5;

  localparam logic [2:0] R_MW_ASCII  = 3'd0;
  localparam logic [2:0] R_MW_UTF8   = 3'd1;
  localparam logic [2:0] R_MW_BINARY = 3'd2;
  localparam logic [2:0] R_MW_JIS    = 3'd3;
  localparam logic [2:0] R_MW_EUCJP  = 3'd4;
  localparam logic [2:0] R_MW_SJIS   = 3'd5;
  localparam logic [2:0] R_UW_JIS    = 3'd6;
  localparam logic [2:0] R_UW_OTHERS = 3'd7;

  localparam logic [29:0] SCORE_CAP = 30'd999999999;

  // Commands from controller to datapath
  typedef struct packed {
    logic       track;     // update trackers with the input beat
    logic       load_enc;  // load numerator/denominator of encoding enc_idx
    logic       div_step;  // one quotient bit
    logic       finish;    // compare score, update best
    logic       clear;     // clear stream state and best
    logic [2:0] enc_idx;
  } teg_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic div_done;
  } teg_sts_t;

endpackage

// ===== rtl/teg_datapath.sv =====
// Byte trackers, counters, serial divider and best-score selection.
module teg_datapath
  import teg_pkg::*;
#(
  parameter int MAX_BYTES = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic [7:0]         data_byte,
  input  teg_cmd_t           cmd,
  output teg_sts_t           sts,
  output logic [ENC_W-1:0]   best_enc,
  output logic [SCORE_W-1:0] best_score
);

  // Counts never exceed the number of bytes examined
  localparam int CNT_W = $clog2(MAX_BYTES + 1);
  localparam int NUM_W = CNT_W + 16;
  localparam int DEN_W = CNT_W + 8;
  localparam int QW    = NUM_W;
  localparam int STEP_W = $clog2(QW + 1);
  localparam logic [CNT_W-1:0] MAXB = CNT_W'(MAX_BYTES);

  // Configuration registers
  logic [15:0] mw_r [NUM_ENC];
  logic [7:0]  uw_jis_r, uw_oth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mw_r[0] <= 16'd10;    mw_r[1] <= 16'd100;   mw_r[2] <= 16'd10000;
      mw_r[3] <= 16'd30000; mw_r[4] <= 16'd100;   mw_r[5] <= 16'd100;
      uw_jis_r <= 8'd1;
      uw_oth_r <= 8'd10;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        R_MW_ASCII:  mw_r[0] <= cfg_wdata;
        R_MW_UTF8:   mw_r[1] <= cfg_wdata;
        R_MW_BINARY: mw_r[2] <= cfg_wdata;
        R_MW_JIS:    mw_r[3] <= cfg_wdata;
        R_MW_EUCJP:  mw_r[4] <= cfg_wdata;
        R_MW_SJIS:   mw_r[5] <= cfg_wdata;
        R_UW_JIS:    uw_jis_r <= cfg_wdata[7:0];
        R_UW_OTHERS: uw_oth_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Tracker state
  logic [1:0] jis_r, jis_nxt, euc_r, euc_nxt;
  logic       sjis_r, sjis_nxt;
  logic [2:0] urem_r, urem_nxt, ulen_r, ulen_nxt;
  logic [CNT_W-1:0] mc_r [NUM_ENC];
  logic [CNT_W-1:0] uc_r [NUM_ENC];
  logic [CNT_W-1:0] mc_nxt [NUM_ENC];
  logic [CNT_W-1:0] uc_nxt [NUM_ENC];
  logic [CNT_W-1:0] seen_r;

  logic [7:0] b;
  logic is_bin, ok;
  logic [2:0] len, rem_dec;
  assign b = data_byte;

  always_comb begin
    jis_nxt = jis_r; euc_nxt = euc_r; sjis_nxt = sjis_r;
    urem_nxt = urem_r; ulen_nxt = ulen_r;
    for (int i = 0; i < NUM_ENC; i++) begin
      mc_nxt[i] = mc_r[i];
      uc_nxt[i] = uc_r[i];
    end
    is_bin = (b <= 8'h06) || (b == 8'h08) || (b == 8'h0b) ||
             (b >= 8'h0e && b <= 8'h1a) || (b >= 8'h1c && b <= 8'h1f) || (b == 8'h7f);
    ok = 1'b0; len = 3'd0; rem_dec = urem_r - 3'd1;
    // byte classes
    if (is_bin) begin
      mc_nxt[E_BINARY] = mc_r[E_BINARY] + 1'b1;
      uc_nxt[E_ASCII]  = uc_r[E_ASCII] + 1'b1;
    end else if (b < 8'h80) begin
      mc_nxt[E_ASCII]  = mc_r[E_ASCII] + 1'b1;
      uc_nxt[E_BINARY] = uc_r[E_BINARY] + 1'b1;
    end else begin
      uc_nxt[E_ASCII]  = uc_r[E_ASCII] + 1'b1;
      uc_nxt[E_BINARY] = uc_r[E_BINARY] + 1'b1;
    end
    // JIS escape
    case (jis_r)
      2'd0: if (b == 8'h1b) jis_nxt = 2'd1;
      2'd1: begin
        if (b == 8'h24) jis_nxt = 2'd2;
        else if (b == 8'h28) jis_nxt = 2'd3;
        else begin
          jis_nxt = 2'd0;
          uc_nxt[E_JIS] = uc_r[E_JIS] + CNT_W'(2);
        end
      end
      default: begin
        jis_nxt = 2'd0;
        if (b == 8'h42) mc_nxt[E_JIS] = mc_r[E_JIS] + CNT_W'(3);
        else            uc_nxt[E_JIS] = uc_r[E_JIS] + CNT_W'(3);
      end
    endcase
    // EUC-JP
    if (euc_r == 2'd0) begin
      if (b == 8'h8e) euc_nxt = 2'd1;
      else if (b >= 8'ha1 && b <= 8'hfe) euc_nxt = 2'd2;
    end else begin
      ok = (euc_r == 2'd1) ? (b >= 8'ha0 && b <= 8'hdf) : (b >= 8'ha1 && b <= 8'hfe);
      euc_nxt = 2'd0;
      if (ok) mc_nxt[E_EUCJP] = mc_r[E_EUCJP] + CNT_W'(2);
      else    uc_nxt[E_EUCJP] = uc_r[E_EUCJP] + CNT_W'(2);
    end
    // Shift-JIS
    if (!sjis_r) begin
      if ((b >= 8'h81 && b <= 8'h9f) || (b >= 8'he0 && b <= 8'hfc)) sjis_nxt = 1'b1;
    end else begin
      sjis_nxt = 1'b0;
      if ((b >= 8'h40 && b <= 8'h7e) || (b >= 8'h80 && b <= 8'hfc))
        mc_nxt[E_SJIS] = mc_r[E_SJIS] + CNT_W'(2);
      else
        uc_nxt[E_SJIS] = uc_r[E_SJIS] + CNT_W'(2);
    end
    // UTF-8
    if (urem_r == 3'd0) begin
      if (b >= 8'hc0 && b <= 8'hdf) len = 3'd2;
      else if (b >= 8'he0 && b <= 8'hef) len = 3'd3;
      else if (b >= 8'hf0 && b <= 8'hf7) len = 3'd4;
      else if (b >= 8'hf8 && b <= 8'hfb) len = 3'd5;
      else if (b >= 8'hfc && b <= 8'hfd) len = 3'd6;
      if (len != 3'd0) begin
        ulen_nxt = len;
        urem_nxt = len - 3'd1;
      end
    end else begin
      urem_nxt = rem_dec;
      if (b >= 8'h80 && b <= 8'hbf) begin
        if (rem_dec == 3'd0) begin
          mc_nxt[E_UTF8] = mc_r[E_UTF8] + CNT_W'(ulen_r);
          ulen_nxt = 3'd0;
        end
      end else begin
        uc_nxt[E_UTF8] = uc_r[E_UTF8] + CNT_W'(ulen_r - rem_dec);
        urem_nxt = 3'd0;
        ulen_nxt = 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      jis_r <= '0; euc_r <= '0; sjis_r <= 1'b0; urem_r <= '0; ulen_r <= '0;
      seen_r <= '0;
      for (int i = 0; i < NUM_ENC; i++) begin
        mc_r[i] <= '0;
        uc_r[i] <= '0;
      end
    end else if (cmd.track && seen_r < MAXB) begin
      seen_r <= seen_r + 1'b1;
      jis_r <= jis_nxt; euc_r <= euc_nxt; sjis_r <= sjis_nxt;
      urem_r <= urem_nxt; ulen_r <= ulen_nxt;
      for (int i = 0; i < NUM_ENC; i++) begin
        mc_r[i] <= mc_nxt[i];
        uc_r[i] <= uc_nxt[i];
      end
    end
  end

  // Score stage: multiply, then restoring division one bit a cycle
  logic [NUM_W-1:0] num_r, rem_r;
  logic [DEN_W-1:0] den_r;
  logic [QW-1:0]    quo_r;
  logic [STEP_W-1:0] step_r;
  logic [DEN_W-1:0] den_raw;
  logic [7:0]       uw_sel;
  logic [NUM_W:0]   trial;
  logic [NUM_W-1:0] shifted;
  logic [SCORE_W-1:0] score;

  assign uw_sel  = (cmd.enc_idx == E_JIS) ? uw_jis_r : uw_oth_r;
  assign den_raw = uc_r[cmd.enc_idx] * uw_sel;
  assign shifted = {rem_r[NUM_W-2:0], num_r[NUM_W-1]};
  assign trial   = {1'b0, shifted} - {{(NUM_W + 1 - DEN_W){1'b0}}, den_r};
  assign sts.div_done = (step_r == STEP_W'(QW));
  assign score = (quo_r > QW'(SCORE_CAP)) ? SCORE_CAP : quo_r[SCORE_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_enc) begin
      num_r  <= mc_r[cmd.enc_idx] * mw_r[cmd.enc_idx];
      den_r  <= (den_raw == '0) ? DEN_W'(1) : den_raw;
      rem_r  <= '0;
      quo_r  <= '0;
      step_r <= '0;
    end else if (cmd.div_step) begin
      num_r  <= {num_r[NUM_W-2:0], 1'b0};
      step_r <= step_r + 1'b1;
      if (!trial[NUM_W]) begin
        rem_r <= trial[NUM_W-1:0];
        quo_r <= {quo_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= shifted;
        quo_r <= {quo_r[QW-2:0], 1'b0};
      end
    end
  end

  // Best so far, first strict maximum wins
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      best_enc   <= E_ASCII;
      best_score <= '0;
    end else if (cmd.finish && score > best_score) begin
      best_enc   <= cmd.enc_idx;
      best_score <= score;
    end
  end

endmodule

// ===== rtl/teg_ctrl.sv =====
// Controller: byte intake, per-encoding score sequence and output register.
module teg_ctrl
  import teg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  logic     in_tlast,
  output logic     out_tvalid,
  input  logic     out_tready,
  output teg_cmd_t cmd,
  input  teg_sts_t sts
);

  typedef enum logic [4:0] {
    S_RUN   = 5'b00001,
    S_LOAD  = 5'b00010,
    S_DIV   = 5'b00100,
    S_NEXT  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       acc;

  assign in_tready  = (state_r == S_RUN);
  assign out_tvalid = (state_r == S_OUT);
  assign acc        = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.enc_idx = idx_r;
    unique case (state_r)
      S_RUN: begin
        cmd.track = acc;
        if (acc && in_tlast) begin
          state_nxt = S_LOAD;
          idx_nxt   = E_ASCII;
        end
      end
      S_LOAD: begin
        cmd.load_enc = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_NEXT;
        else cmd.div_step = 1'b1;
      end
      S_NEXT: begin
        cmd.finish = 1'b1;
        if (idx_r == E_SJIS) state_nxt = S_OUT;
        else begin
          idx_nxt   = idx_r + 3'd1;
          state_nxt = S_LOAD;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          cmd.clear = 1'b1;
          state_nxt = S_RUN;
        end
      end
      default: state_nxt = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// ===== rtl/text_encoding_guesser_top.sv =====
// Text encoding guesser: one byte per cycle while in_tready is high, result after the last byte.
// Throughput: one byte a cycle while a stream runs.
// After the last byte, the bit-serial divider, shared by the six encodings, scores
// each encoding in turn; no bytes are taken then.
// Reset (rst_n low, synchronous) restores default weights, clears all counts.
module text_encoding_guesser_top
  import teg_pkg::*;
#(
  parameter int MAX_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tlast,   // final_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // encoding[2:0], best_score[32:3], zero pad
);

  teg_cmd_t cmd;
  teg_sts_t sts;
  logic [ENC_W-1:0]   enc;
  logic [SCORE_W-1:0] score;

  teg_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tlast,
    .out_tvalid, .out_tready, .cmd, .sts
  );

  teg_datapath #(.MAX_BYTES(MAX_BYTES)) u_dp (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_wdata,
    .data_byte(in_tdata), .cmd, .sts, .best_enc(enc), .best_score(score)
  );

  assign out_tdata = {7'd0, score, enc};

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the text encoding guesser stream block.
module tb_top;
  import teg_pkg::*;

  // Expected verdicts, one per stream
  class verdict_board;
    logic [ENC_W-1:0]   enc_q[$];
    logic [SCORE_W-1:0] score_q[$];
    int errors = 0;

    function void note_stream(logic [ENC_W-1:0] e, logic [SCORE_W-1:0] s);
      enc_q.push_back(e);
      score_q.push_back(s);
    endfunction

    function void check_verdict(logic [ENC_W-1:0] e, logic [SCORE_W-1:0] s,
                                 logic [6:0] pad);
      logic [ENC_W-1:0] xe;
      logic [SCORE_W-1:0] xs;
      if (enc_q.size() == 0) begin
        $display("%0t: unexpected beat enc=%0d score=%0d", $time, e, s);
        errors++;
        return;
      end
      xe = enc_q.pop_front();
      xs = score_q.pop_front();
      if (xe !== e) begin
        $display("%0t: encoding mismatch expected %0d actual %0d", $time, xe, e);
        errors++;
      end
      if (xs !== s) begin
        $display("%0t: score mismatch expected %0d actual %0d", $time, xs, s);
        errors++;
      end
      if (pad !== 7'd0) begin
        $display("%0t: pad mismatch expected 0 actual %0h", $time, pad);
        errors++;
      end
    endfunction

    function int pending();
      return enc_q.size();
    endfunction
  endclass

  localparam int MAXB = 65536;
  localparam int LAT = 6 * (17 + 19) + 20;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_wr_en = 0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [39:0] out_tdata;

  int send_idle = 0;
  int recv_idle = 0;
  bit hold_recv = 0;

  text_encoding_guesser_top u_dut (.*);

  always #5 clk = ~clk;

  verdict_board board = new();

  // Predictor state
  logic [15:0] weight_m[NUM_ENC];
  logic [7:0]  weight_jis_u, weight_oth_u;
  int unsigned hits[NUM_ENC], misses[NUM_ENC];
  int unsigned jis_st, euc_st, sjis_st, u8_left, u8_len, seen;

  function automatic void clear_counts();
    for (int i = 0; i < NUM_ENC; i++) begin
      hits[i] = 0;
      misses[i] = 0;
    end
    jis_st = 0; euc_st = 0; sjis_st = 0; u8_left = 0; u8_len = 0; seen = 0;
  endfunction

  function automatic bit ctrl_byte(logic [7:0] b);
    return b <= 8'h06 || b == 8'h08 || b == 8'h0b || (b >= 8'h0e && b <= 8'h1a) ||
           (b >= 8'h1c && b <= 8'h1f) || b == 8'h7f;
  endfunction

  // Track one byte; on the last one, push the expected verdict
  function automatic void predict_byte(logic [7:0] b, bit last);
    longint unsigned num, den, q;
    logic [SCORE_W-1:0] top_s;
    logic [ENC_W-1:0] top_e;
    int unsigned n;
    bit ok;
    if (seen < MAXB) begin
      seen++;
      if (ctrl_byte(b)) begin
        hits[E_BINARY]++; misses[E_ASCII]++;
      end else if (b < 8'h80) begin
        hits[E_ASCII]++; misses[E_BINARY]++;
      end else begin
        misses[E_ASCII]++; misses[E_BINARY]++;
      end
      // JIS escape
      case (jis_st)
        0: if (b == 8'h1b) jis_st = 1;
        1: begin
          if (b == 8'h24) jis_st = 2;
          else if (b == 8'h28) jis_st = 3;
          else begin jis_st = 0; misses[E_JIS] += 2; end
        end
        default: begin
          jis_st = 0;
          if (b == 8'h42) hits[E_JIS] += 3; else misses[E_JIS] += 3;
        end
      endcase
      // EUC-JP pairs
      if (euc_st == 0) begin
        if (b == 8'h8e) euc_st = 1;
        else if (b >= 8'ha1 && b <= 8'hfe) euc_st = 2;
      end else begin
        ok = (euc_st == 1) ? (b >= 8'ha0 && b <= 8'hdf) : (b >= 8'ha1 && b <= 8'hfe);
        euc_st = 0;
        if (ok) hits[E_EUCJP] += 2; else misses[E_EUCJP] += 2;
      end
      // Shift-JIS pairs
      if (sjis_st == 0) begin
        if ((b >= 8'h81 && b <= 8'h9f) || (b >= 8'he0 && b <= 8'hfc)) sjis_st = 1;
      end else begin
        sjis_st = 0;
        if ((b >= 8'h40 && b <= 8'h7e) || (b >= 8'h80 && b <= 8'hfc)) hits[E_SJIS] += 2;
        else misses[E_SJIS] += 2;
      end
      // UTF-8 sequences
      if (u8_left == 0) begin
        n = 0;
        if (b >= 8'hc0 && b <= 8'hdf) n = 2;
        else if (b >= 8'he0 && b <= 8'hef) n = 3;
        else if (b >= 8'hf0 && b <= 8'hf7) n = 4;
        else if (b >= 8'hf8 && b <= 8'hfb) n = 5;
        else if (b >= 8'hfc && b <= 8'hfd) n = 6;
        if (n != 0) begin u8_len = n; u8_left = n - 1; end
      end else begin
        u8_left--;
        if (b >= 8'h80 && b <= 8'hbf) begin
          if (u8_left == 0) begin hits[E_UTF8] += u8_len; u8_len = 0; end
        end else begin
          misses[E_UTF8] += u8_len - u8_left;
          u8_left = 0; u8_len = 0;
        end
      end
    end
    if (!last) return;
    top_s = '0;
    top_e = E_ASCII;
    for (int i = 0; i < NUM_ENC; i++) begin
      num = longint'(hits[i]) * weight_m[i];
      den = longint'(misses[i]) * ((i == E_JIS) ? weight_jis_u : weight_oth_u);
      if (den == 0) den = 1;
      q = num / den;
      if (q > SCORE_CAP) q = SCORE_CAP;
      if (q > top_s) begin top_s = q[SCORE_W-1:0]; top_e = i[ENC_W-1:0]; end
    end
    board.note_stream(top_e, top_s);
    clear_counts();
  endfunction

  // One register write, then the write enable is dropped and the port idles
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_wr_en <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 0;
    case (idx)
      R_UW_JIS:    weight_jis_u = val[7:0];
      R_UW_OTHERS: weight_oth_u = val[7:0];
      default:     weight_m[idx] = val;
    endcase
    @(posedge clk);
  endtask

  // Offer one byte, with random idling before it
  task automatic send_byte(logic [7:0] b, bit last);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_tvalid <= 1; in_tdata <= b; in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    predict_byte(b, last);
  endtask

  task automatic quiesce();
    in_tvalid <= 0;
    while (board.pending() != 0) @(posedge clk);
    repeat (LAT) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte(int flavor);
    case (flavor)
      0: return 8'($urandom_range(8'h7f));
      1: return 8'($urandom_range(8'hbf, 8'h80));
      2: return 8'($urandom_range(8'hfe, 8'ha1));
      3: return 8'($urandom_range(8'hfc, 8'h81));
      4: return 8'($urandom_range(8'hfd, 8'hc0));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Well-formed fragments with random content, plus noise
  task automatic rand_stream(int len);
    int k, f, n;
    logic [7:0] buf_q[$];
    while (buf_q.size() < len) begin
      f = $urandom_range(9);
      case (f)
        0: begin
          buf_q.push_back(8'h1b);
          buf_q.push_back($urandom_range(1) ? 8'h24 : 8'h28);
          buf_q.push_back($urandom_range(3) != 0 ? 8'h42 : pick_byte(5));
        end
        1: begin
          buf_q.push_back(8'h8e);
          buf_q.push_back($urandom_range(3) != 0 ? 8'($urandom_range(8'hdf, 8'ha0))
                                               : pick_byte(5));
        end
        2: begin buf_q.push_back(pick_byte(2)); buf_q.push_back(pick_byte(2)); end
        3: begin buf_q.push_back(pick_byte(3)); buf_q.push_back(pick_byte(5)); end
        4: begin
          n = $urandom_range(6, 2);
          case (n)
            2: buf_q.push_back(8'($urandom_range(8'hdf, 8'hc0)));
            3: buf_q.push_back(8'($urandom_range(8'hef, 8'he0)));
            4: buf_q.push_back(8'($urandom_range(8'hf7, 8'hf0)));
            5: buf_q.push_back(8'($urandom_range(8'hfb, 8'hf8)));
            default: buf_q.push_back(8'($urandom_range(8'hfd, 8'hfc)));
          endcase
          for (k = 1; k < n; k++)
            buf_q.push_back($urandom_range(7) != 0 ? pick_byte(1) : pick_byte(5));
        end
        5, 6: buf_q.push_back(pick_byte(0));
        default: buf_q.push_back(pick_byte(5));
      endcase
    end
    for (k = 0; k < len; k++) send_byte(buf_q[k], k == len - 1);
  endtask

  // Receiver with random stalls and one optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else if (hold_recv) out_tready <= 0;
    else out_tready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
    if (rst_n && out_tvalid && out_tready)
      board.check_verdict(out_tdata[2:0], out_tdata[32:3], out_tdata[39:33]);
  end

  task automatic random_weights();
    for (int r = 0; r < 8; r++)
      write_reg(r[2:0], (r >= 6) ? 16'($urandom_range(255)) : 16'($urandom_range(16'hffff)));
  endtask

  initial begin
    int done;
    weight_m = '{16'd10, 16'd100, 16'd10000, 16'd30000, 16'd100, 16'd100};
    weight_jis_u = 8'd1; weight_oth_u = 8'd10;
    clear_counts();
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: single bytes at the extremes, each tracker's cases
    send_byte(8'h00, 1);
    send_byte(8'hff, 1);
    send_byte(8'h41, 1);
    send_byte(8'h80, 1);
    send_byte(8'h1b, 0); send_byte(8'h24, 0); send_byte(8'h42, 1);
    send_byte(8'h1b, 0); send_byte(8'h28, 0); send_byte(8'h41, 1);
    send_byte(8'h1b, 0); send_byte(8'h1b, 1);
    send_byte(8'h8e, 0); send_byte(8'ha0, 0); send_byte(8'ha1, 0); send_byte(8'hfe, 1);
    send_byte(8'h81, 0); send_byte(8'h40, 0); send_byte(8'hfc, 0); send_byte(8'h7f, 1);
    send_byte(8'hfd, 0); send_byte(8'hbf, 0); send_byte(8'h41, 1);
    quiesce();

    // Weight extremes: all zero, then all ones
    for (int r = 0; r < 8; r++) write_reg(r[2:0], 16'h0000);
    rand_stream(12);
    quiesce();
    for (int r = 0; r < 8; r++) write_reg(r[2:0], 16'hffff);
    send_byte(8'h41, 1);
    rand_stream(20);
    quiesce();

    // Random phases with idling profiles
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 23 : (ph == 1) ? 84 : 0;
      recv_idle = (ph == 0) ? 84 : (ph == 1) ? 23 : 0;
      random_weights();
      done = 0;
      while (done < 600) begin
        int len = $urandom_range(9) == 0 ? $urandom_range(60, 20) : $urandom_range(12, 1);
        rand_stream(len);
        done += len;
      end
      quiesce();
    end

    // Long receiver hold-off while streams keep arriving
    hold_recv = 1;
    fork
      begin repeat (3000) @(posedge clk); hold_recv = 0; end
      for (int s = 0; s < 6; s++) rand_stream($urandom_range(4, 1));
    join
    quiesce();

    // Closing short stream with the default ASCII weight
    write_reg(R_MW_ASCII, 16'd10);
    rand_stream(5);
    quiesce();

    if (board.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/teg_pkg.sv
rtl/teg_datapath.sv
rtl/teg_ctrl.sv
rtl/text_encoding_guesser_top.sv
tb/sv/tb_top.sv
